### rtl/ntcti_pkg.sv
`default_nettype none
package ntcti_pkg;

	// Field widths of the two channels.
	localparam int SAMPLE_W = 14;
	localparam int TEMP_W   = 12;

	// Table geometry: entry k stands for k - 40 degrees.
	localparam int TBL_LEN = 161;
	localparam int IDX_W   = 8;
	// Largest step between neighbor entries fits in this width.
	localparam int DIFF_W  = 8;
	// Ten times a step, the running remainder of the divider.
	localparam int REM_W   = 12;
	// Quotient of 10*r/d lies in 0..10.
	localparam int QUO_W   = 4;

	localparam logic [IDX_W-1:0]         K_ZERO   = 8'd40;
	localparam logic signed [TEMP_W-1:0] TEMP_MIN = -12'sd400;
	localparam logic signed [TEMP_W-1:0] TEMP_MAX = 12'sd1200;

	// Converter mode codes.
	localparam logic MODE_14BIT = 1'b0;
	localparam logic MODE_10BIT = 1'b1;

	localparam logic [SAMPLE_W-1:0] TBL_HI [0:TBL_LEN-1] = '{
		14'd15813, 14'd15785, 14'd15754, 14'd15720, 14'd15683, 14'd15644, 14'd15602,
		14'd15556, 14'd15509, 14'd15458, 14'd15404, 14'd15347, 14'd15287, 14'd15224,
		14'd15158, 14'd15089, 14'd15018, 14'd14943, 14'd14865, 14'd14785, 14'd14702,
		14'd14618, 14'd14531, 14'd14441, 14'd14349, 14'd14254, 14'd14156, 14'd14054,
		14'd13950, 14'd13843, 14'd13733, 14'd13620, 14'd13504, 14'd13384, 14'd13262,
		14'd13136, 14'd13008, 14'd12875, 14'd12740, 14'd12602, 14'd12461, 14'd12313,
		14'd12163, 14'd12009, 14'd11853, 14'd11694, 14'd11532, 14'd11369, 14'd11202,
		14'd11035, 14'd10863, 14'd10691, 14'd10518, 14'd10342, 14'd10166, 14'd9989,
		14'd9812, 14'd9630, 14'd9450, 14'd9273, 14'd9092, 14'd8909, 14'd8731,
		14'd8548, 14'd8372, 14'd8192, 14'd8014, 14'd7837, 14'd7661, 14'd7487,
		14'd7314, 14'd7143, 14'd6973, 14'd6806, 14'd6640, 14'd6477, 14'd6316,
		14'd6157, 14'd6000, 14'd5846, 14'd5694, 14'd5546, 14'd5399, 14'd5256,
		14'd5115, 14'd4977, 14'd4842, 14'd4709, 14'd4580, 14'd4453, 14'd4330,
		14'd4209, 14'd4091, 14'd3976, 14'd3864, 14'd3754, 14'd3647, 14'd3543,
		14'd3441, 14'd3343, 14'd3247, 14'd3154, 14'd3062, 14'd2974, 14'd2889,
		14'd2805, 14'd2724, 14'd2646, 14'd2569, 14'd2494, 14'd2422, 14'd2353,
		14'd2285, 14'd2219, 14'd2156, 14'd2093, 14'd2033, 14'd1975, 14'd1918,
		14'd1864, 14'd1811, 14'd1759, 14'd1710, 14'd1661, 14'd1614, 14'd1569,
		14'd1526, 14'd1483, 14'd1442, 14'd1403, 14'd1364, 14'd1327, 14'd1290,
		14'd1255, 14'd1221, 14'd1188, 14'd1155, 14'd1124, 14'd1094, 14'd1064,
		14'd1035, 14'd1008, 14'd982, 14'd956, 14'd931, 14'd907, 14'd883,
		14'd859, 14'd836, 14'd814, 14'd792, 14'd771, 14'd751, 14'd731,
		14'd711, 14'd692, 14'd674, 14'd656, 14'd638, 14'd622, 14'd605
	};

	localparam logic [SAMPLE_W-1:0] TBL_LO [0:TBL_LEN-1] = '{
		14'd987, 14'd986, 14'd984, 14'd982, 14'd979, 14'd977, 14'd974, 14'd971,
		14'd968, 14'd965, 14'd962, 14'd958, 14'd955, 14'd951, 14'd946, 14'd942,
		14'd938, 14'd933, 14'd928, 14'd923, 14'd918, 14'd913, 14'd907, 14'd902,
		14'd896, 14'd890, 14'd884, 14'd878, 14'd871, 14'd864, 14'd858, 14'd850,
		14'd843, 14'd836, 14'd828, 14'd820, 14'd812, 14'd804, 14'd796, 14'd787,
		14'd778, 14'd769, 14'd759, 14'd750, 14'd740, 14'd730, 14'd720, 14'd710,
		14'd699, 14'd689, 14'd678, 14'd668, 14'd657, 14'd646, 14'd635, 14'd624,
		14'd613, 14'd601, 14'd590, 14'd579, 14'd568, 14'd556, 14'd545, 14'd534,
		14'd523, 14'd512, 14'd500, 14'd489, 14'd478, 14'd468, 14'd457, 14'd446,
		14'd435, 14'd425, 14'd415, 14'd404, 14'd394, 14'd384, 14'd375, 14'd365,
		14'd356, 14'd346, 14'd337, 14'd328, 14'd319, 14'd311, 14'd302, 14'd294,
		14'd286, 14'd278, 14'd270, 14'd263, 14'd255, 14'd248, 14'd241, 14'd234,
		14'd228, 14'd221, 14'd215, 14'd209, 14'd203, 14'd197, 14'd191, 14'd186,
		14'd180, 14'd175, 14'd170, 14'd165, 14'd160, 14'd156, 14'd151, 14'd147,
		14'd143, 14'd139, 14'd135, 14'd131, 14'd127, 14'd123, 14'd120, 14'd116,
		14'd113, 14'd110, 14'd107, 14'd104, 14'd101, 14'd98, 14'd95, 14'd93,
		14'd90, 14'd88, 14'd85, 14'd83, 14'd81, 14'd78, 14'd76, 14'd74,
		14'd72, 14'd70, 14'd68, 14'd66, 14'd65, 14'd63, 14'd61, 14'd60,
		14'd58, 14'd57, 14'd55, 14'd54, 14'd52, 14'd51, 14'd49, 14'd48,
		14'd47, 14'd46, 14'd44, 14'd43, 14'd42, 14'd41, 14'd40, 14'd39,
		14'd38
	};

	// Classified sample handed from the front end to the divider.
	typedef struct packed {
		logic              sat_lo;
		logic              sat_hi;
		logic [IDX_W-1:0]  k;
		logic [DIFF_W-1:0] r;
		logic [DIFF_W-1:0] d;
	} front_word_t;

	// One stage of the divider pipeline.
	typedef struct packed {
		logic              sat_lo;
		logic              sat_hi;
		logic [IDX_W-1:0]  k;
		logic [REM_W-1:0]  rem;
		logic [DIFF_W-1:0] d;
		logic [QUO_W-1:0]  q;
	} div_word_t;

	// Table entry k of the table that the mode selects.
	function automatic logic [SAMPLE_W-1:0] tbl_entry(input logic mode, input int k);
		tbl_entry = (mode == MODE_10BIT) ? TBL_LO[k] : TBL_HI[k];
	endfunction

endpackage
`default_nettype wire

### rtl/ntcti_ifs.sv
`default_nettype none
// Sample channel: one converter reading per word.
interface ntcti_sample_if;
	import ntcti_pkg::*;
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;
	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

// Temperature channel: one result per word.
interface ntcti_temp_if;
	import ntcti_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [TEMP_W-1:0] temp_tenths;
	modport source (output valid, output temp_tenths, input ready);
	modport sink (input valid, input temp_tenths, output ready);
endinterface
`default_nettype wire

### rtl/ntcti_fifo.sv
`default_nettype none
module ntcti_fifo #(
	parameter int DEPTH = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire ntcti_pkg::front_word_t in_word,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output ntcti_pkg::front_word_t     out_word
);
	import ntcti_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	front_word_t      store_q [0:DEPTH-1];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign in_ready  = (count_q != CNT_FULL);
	assign out_valid = (count_q != '0);
	assign out_word  = store_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Word storage.
	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= in_word;
		end
	end
endmodule
`default_nettype wire

### rtl/ntcti_front.sv
`default_nettype none
module ntcti_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  mode,
	ntcti_sample_if.sink               sample_ch,
	output logic                       word_valid,
	input  wire logic                  word_ready,
	output ntcti_pkg::front_word_t     word
);
	import ntcti_pkg::*;

	logic                valid_s1;
	logic                valid_s2;
	logic                valid_s3;
	logic                rdy_s1;
	logic                rdy_s2;
	logic                rdy_s3;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [SAMPLE_W-1:0] sample_s2;
	logic                mode_s1;
	logic                mode_s2;
	logic [TBL_LEN-1:0]  hit;
	logic [TBL_LEN-1:0]  hit_s2;
	logic [TBL_LEN-1:0]  first;
	logic [IDX_W-1:0]    k_idx;
	logic [SAMPLE_W-1:0] t_k;
	logic [SAMPLE_W-1:0] t_km1;
	logic [SAMPLE_W-1:0] r_full;
	logic [SAMPLE_W-1:0] d_full;
	front_word_t         cls;
	front_word_t         word_s3;

	// A stage moves when it is empty or the next one moves.
	assign rdy_s3 = !valid_s3 || word_ready;
	assign rdy_s2 = !valid_s2 || rdy_s3;
	assign rdy_s1 = !valid_s1 || rdy_s2;
	assign sample_ch.ready = rdy_s1;
	assign word_valid = valid_s3;
	assign word = word_s3;

	// Compare the sample against every entry of the selected table.
	always_comb begin
		for (int k = 0; k < TBL_LEN; k++) begin
			hit[k] = (sample_s1 > tbl_entry(mode_s1, k));
		end
	end

	// The hits form a run up to the last entry; pick its first entry and
	// fetch that entry and the one above it.
	always_comb begin
		first = hit_s2 & ~{hit_s2[TBL_LEN-2:0], 1'b0};
		k_idx = '0;
		t_k   = '0;
		t_km1 = '0;
		for (int k = 0; k < TBL_LEN; k++) begin
			if (first[k]) begin
				k_idx = k_idx | IDX_W'(k);
				t_k   = t_k | tbl_entry(mode_s2, k);
				if (k > 0) begin
					t_km1 = t_km1 | tbl_entry(mode_s2, k - 1);
				end
			end
		end
		r_full     = sample_s2 - t_k;
		d_full     = t_km1 - t_k;
		cls.sat_lo = hit_s2[0];
		cls.sat_hi = !hit_s2[TBL_LEN-1];
		cls.k      = k_idx;
		cls.r      = r_full[DIFF_W-1:0];
		cls.d      = d_full[DIFF_W-1:0];
	end

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= sample_ch.valid;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			sample_s1 <= sample_ch.sample;
			mode_s1   <= mode;
		end
		if (rdy_s2) begin
			sample_s2 <= sample_s1;
			mode_s2   <= mode_s1;
			hit_s2    <= hit;
		end
		if (rdy_s3) begin
			word_s3 <= cls;
		end
	end
endmodule
`default_nettype wire

### rtl/ntcti_back.sv
`default_nettype none
module ntcti_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  word_valid,
	output logic                       word_ready,
	input  wire ntcti_pkg::front_word_t word,
	ntcti_temp_if.source               temp_ch
);
	import ntcti_pkg::*;

	// Stage 0 loads 10*r, stages 1..QUO_W each settle one quotient bit.
	localparam int NSTG = QUO_W + 1;

	div_word_t                div_s [0:NSTG-1];
	div_word_t                div_nxt [0:NSTG-1];
	logic [NSTG-1:0]          vld_s;
	logic [NSTG:0]            rdy;
	logic                     out_vld_q;
	logic signed [TEMP_W-1:0] temp_q;
	logic signed [TEMP_W-1:0] temp_nxt;
	logic [TEMP_W-1:0]        k_ten;
	logic signed [TEMP_W:0]   interp;
	logic                     round_up;

	// Ready chain from the output register back to the queue.
	always_comb begin
		rdy[NSTG] = !out_vld_q || temp_ch.ready;
		for (int i = NSTG - 1; i >= 0; i--) begin
			rdy[i] = !vld_s[i] || rdy[i+1];
		end
	end

	assign word_ready          = rdy[0];
	assign temp_ch.valid       = out_vld_q;
	assign temp_ch.temp_tenths = temp_q;

	// Load stage and restoring division steps of 10*r by d.
	always_comb begin
		logic [REM_W-1:0] dsh;
		div_nxt[0].sat_lo = word.sat_lo;
		div_nxt[0].sat_hi = word.sat_hi;
		div_nxt[0].k      = word.k;
		div_nxt[0].rem    = REM_W'({word.r, 3'b000}) + REM_W'({word.r, 1'b0});
		div_nxt[0].d      = word.d;
		div_nxt[0].q      = '0;
		for (int i = 1; i < NSTG; i++) begin
			div_nxt[i] = div_s[i-1];
			dsh = REM_W'(div_s[i-1].d) << (QUO_W - i);
			if (div_s[i-1].rem >= dsh) begin
				div_nxt[i].rem          = div_s[i-1].rem - dsh;
				div_nxt[i].q[QUO_W - i] = 1'b1;
			end
		end
	end

	// Final result: 10*(k-40) less the quotient, truncated toward zero.
	// Above 0 degrees the value is positive, so a nonzero remainder
	// takes one more tenth off.
	always_comb begin
		k_ten    = TEMP_W'({div_s[NSTG-1].k, 3'b000}) + TEMP_W'({div_s[NSTG-1].k, 1'b0});
		round_up = (div_s[NSTG-1].k > K_ZERO) && (div_s[NSTG-1].rem != '0);
		interp   = $signed({1'b0, k_ten}) - (TEMP_W + 1)'(400)
			- $signed({{(TEMP_W + 1 - QUO_W){1'b0}}, div_s[NSTG-1].q})
			- $signed({{TEMP_W{1'b0}}, round_up});
		if (div_s[NSTG-1].sat_lo) begin
			temp_nxt = TEMP_MIN;
		end else if (div_s[NSTG-1].sat_hi) begin
			temp_nxt = TEMP_MAX;
		end else begin
			temp_nxt = interp[TEMP_W-1:0];
		end
	end

	// Valid flags of the divider stages and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (rdy[0]) vld_s[0] <= word_valid;
			for (int i = 1; i < NSTG; i++) begin
				if (rdy[i]) vld_s[i] <= vld_s[i-1];
			end
			if (rdy[NSTG]) out_vld_q <= vld_s[NSTG-1];
		end
	end

	// Divider payloads and the output word.
	always_ff @(posedge clk) begin
		for (int i = 0; i < NSTG; i++) begin
			if (rdy[i]) div_s[i] <= div_nxt[i];
		end
		if (rdy[NSTG]) temp_q <= temp_nxt;
	end
endmodule
`default_nettype wire

### rtl/ntc_table_interpolate_temperature.sv
`default_nettype none
// Channel     Dir  Payload                       Handshake
// sample_ch   in   sample [13:0] unsigned        valid/ready
// temp_ch     out  temp_tenths [11:0] signed     valid/ready
// cfg         in   cfg_wdata (converter mode)    cfg_we, no wait
//
// One word is taken per cycle while temp_ch is not stalled. A word passes the
// front-end stages (input, compare against all 161 entries, pick the bracket),
// the queue, the divider (a load stage, then one quotient bit per stage) and
// the output register.
// Reset clears the valid flags, the queue and the mode register (14-bit table).
// A stall at temp_ch backs up the divider, then the queue, then the front end.
module ntc_table_interpolate_temperature #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic cfg_wdata,
	ntcti_sample_if.sink  sample_ch,
	ntcti_temp_if.source  temp_ch
);
	import ntcti_pkg::*;

	logic        mode_q;
	logic        f_valid;
	logic        f_ready;
	front_word_t f_word;
	logic        q_valid;
	logic        q_ready;
	front_word_t q_word;

	// Converter mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_14BIT;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// Front end: compare and classify.
	ntcti_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode       (mode_q),
		.sample_ch  (sample_ch),
		.word_valid (f_valid),
		.word_ready (f_ready),
		.word       (f_word)
	);

	// Queue between front end and divider.
	ntcti_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_word   (f_word),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_word  (q_word)
	);

	// Back end: divide and form the temperature.
	ntcti_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_valid (q_valid),
		.word_ready (q_ready),
		.word       (q_word),
		.temp_ch    (temp_ch)
	);
endmodule
`default_nettype wire
